// ===== src/fpc_pkg.sv =====
// Shared types and constants for the frustum point cull block.
package fpc_pkg;

   // Item kinds carried on the request channel
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TEST = 1'b1;

   // Matrix shape and plane count
   localparam int PLANE_COUNT = 6;
   localparam int ROW_COUNT   = 4;
   localparam int AXIS_COUNT  = 3;
   localparam int COLUMN_W    = 2;

   // Result queue sizing: deeper than the cell chain so tests stream at full rate
   localparam int FIFO_DEPTH = 32;
   localparam int PTR_W      = 5;
   localparam int CNT_W      = 6;

   // Control group handed from cell to cell
   typedef struct packed {
      logic                valid;
      logic                kind;
      logic [COLUMN_W-1:0] column;
      logic                in_view;
   } ctl_type;

endpackage

// ===== src/fpc_cell.sv =====
// One plane cell: holds its four coefficients, tests passing points, forwards words.
module fpc_cell #(
   parameter int VALUE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16,
   parameter int PLANE_INDEX   = 0
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  fpc_pkg::ctl_type                               in_ctl,
   input  logic [fpc_pkg::ROW_COUNT-1:0][VALUE_WIDTH-1:0]  in_rows,
   input  logic [fpc_pkg::AXIS_COUNT-1:0][VALUE_WIDTH-1:0] in_point,
   output fpc_pkg::ctl_type                               out_ctl,
   output logic [fpc_pkg::ROW_COUNT-1:0][VALUE_WIDTH-1:0]  out_rows,
   output logic [fpc_pkg::AXIS_COUNT-1:0][VALUE_WIDTH-1:0] out_point
);

   // Plane role: even planes add the selected row to row 3, odd planes subtract it
   localparam int ROW_SEL  = PLANE_INDEX / 2;
   localparam bit SUBTRACT = (PLANE_INDEX % 2) == 1;
   localparam int COEF_W   = VALUE_WIDTH + 1;
   localparam int PROD_W   = 2 * VALUE_WIDTH + 1;
   localparam int SUM_W    = 2 * VALUE_WIDTH + FRACTION_BITS + 3;

   logic signed [COEF_W-1:0] coef_ff [0:fpc_pkg::ROW_COUNT-1];
   logic signed [COEF_W-1:0] coef_in;
   logic signed [COEF_W-1:0] r3_ext;
   logic signed [COEF_W-1:0] rk_ext;

   logic signed [PROD_W-1:0] prod_in [0:fpc_pkg::AXIS_COUNT-1];
   logic signed [PROD_W-1:0] prod_ff [0:fpc_pkg::AXIS_COUNT-1];
   logic signed [COEF_W-1:0] w_ff;
   fpc_pkg::ctl_type         ctl1_ff;
   logic [fpc_pkg::ROW_COUNT-1:0][VALUE_WIDTH-1:0]  rows1_ff;
   logic [fpc_pkg::AXIS_COUNT-1:0][VALUE_WIDTH-1:0] point1_ff;

   logic signed [SUM_W-1:0]  sum_a_in;
   logic signed [SUM_W-1:0]  sum_b_in;
   logic signed [SUM_W-1:0]  sum_a_ff;
   logic signed [SUM_W-1:0]  sum_b_ff;
   fpc_pkg::ctl_type         ctl2_ff;
   logic [fpc_pkg::ROW_COUNT-1:0][VALUE_WIDTH-1:0]  rows2_ff;
   logic [fpc_pkg::AXIS_COUNT-1:0][VALUE_WIDTH-1:0] point2_ff;

   logic signed [SUM_W-1:0]  total;
   fpc_pkg::ctl_type         ctl3_in;
   fpc_pkg::ctl_type         ctl3_ff;
   logic [fpc_pkg::ROW_COUNT-1:0][VALUE_WIDTH-1:0]  rows3_ff;
   logic [fpc_pkg::AXIS_COUNT-1:0][VALUE_WIDTH-1:0] point3_ff;

   // New coefficient for this plane from an arriving load word
   assign r3_ext  = COEF_W'($signed(in_rows[3]));
   assign rk_ext  = COEF_W'($signed(in_rows[ROW_SEL]));
   assign coef_in = SUBTRACT ? (r3_ext - rk_ext) : (r3_ext + rk_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fpc_pkg::ROW_COUNT; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (in_ctl.valid && in_ctl.kind == fpc_pkg::KIND_LOAD) begin
         coef_ff[in_ctl.column] <= coef_in;
      end
   end

   // Stage 1: the three normal products, captured with the w term
   always_comb begin
      for (int i = 0; i < fpc_pkg::AXIS_COUNT; i++) begin
         prod_in[i] = PROD_W'(coef_ff[i]) * PROD_W'($signed(in_point[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
      end else begin
         ctl1_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < fpc_pkg::AXIS_COUNT; i++) begin
         prod_ff[i] <= prod_in[i];
      end
      w_ff      <= coef_ff[3];
      rows1_ff  <= in_rows;
      point1_ff <= in_point;
   end

   // Stage 2: pairwise sums; w is lifted to the product scale
   assign sum_a_in = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]);
   assign sum_b_in = SUM_W'(prod_ff[2]) + (SUM_W'(w_ff) <<< FRACTION_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
      end else begin
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      sum_a_ff  <= sum_a_in;
      sum_b_ff  <= sum_b_in;
      rows2_ff  <= rows1_ff;
      point2_ff <= point1_ff;
   end

   // Stage 3: final sum; a negative distance clears the in-view flag
   assign total = sum_a_ff + sum_b_ff;

   always_comb begin
      ctl3_in = ctl2_ff;
      if (ctl2_ff.kind == fpc_pkg::KIND_TEST && total[SUM_W-1]) begin
         ctl3_in.in_view = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
      end else begin
         ctl3_ff <= ctl3_in;
      end
   end

   always_ff @(posedge clock) begin
      rows3_ff  <= rows2_ff;
      point3_ff <= point2_ff;
   end

   assign out_ctl   = ctl3_ff;
   assign out_rows  = rows3_ff;
   assign out_point = point3_ff;

endmodule

// ===== src/fpc_fifo.sv =====
// Result queue between the cell chain and the response channel.
module fpc_fifo (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic push_data,
   input  logic pop,
   output logic out_valid,
   output logic out_data
);

   logic                        mem_ff [0:fpc_pkg::FIFO_DEPTH-1];
   logic [fpc_pkg::PTR_W-1:0]   wr_ptr_ff;
   logic [fpc_pkg::PTR_W-1:0]   rd_ptr_ff;
   logic [fpc_pkg::CNT_W-1:0]   count_ff;
   logic [fpc_pkg::CNT_W-1:0]   count_in;
   logic                        do_pop;

   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && out_valid;

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count
   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== src/frustum_point_cull.sv =====
// Top level of the frustum point cull block: six plane cells in a row plus a result queue.
//
// Each request word either loads one view-projection matrix column (kind 0) or tests a
// point (kind 1). Words enter a chain of six plane cells, one per frustum plane; a load
// word updates each plane's coefficient for its column as it passes that cell, so a test
// always sees exactly the loads accepted before it. Each cell has three register stages
// (products, pairwise sums, final sum and sign), which a test word's result passes through
// on its way to the queue. One word is accepted every cycle while req_stall is low;
// req_stall rises only when 32 test results are in flight or waiting in the queue, which
// happens only while the response side holds rsp_stall. Loads produce no response word.
// Planes reset to zero, so until loaded every point reports inside.
module frustum_point_cull #(
   parameter int VALUE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [fpc_pkg::COLUMN_W-1:0]  req_column,
   input  logic signed [VALUE_WIDTH-1:0] req_row0_value,
   input  logic signed [VALUE_WIDTH-1:0] req_row1_value,
   input  logic signed [VALUE_WIDTH-1:0] req_row2_value,
   input  logic signed [VALUE_WIDTH-1:0] req_row3_value,
   input  logic signed [VALUE_WIDTH-1:0] req_point_x,
   input  logic signed [VALUE_WIDTH-1:0] req_point_y,
   input  logic signed [VALUE_WIDTH-1:0] req_point_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_inside_res
);

   logic                        req_accept;
   logic                        rsp_accept;
   logic                        result_push;
   logic [fpc_pkg::CNT_W-1:0]   pending_ff;
   logic [fpc_pkg::CNT_W-1:0]   pending_in;

   fpc_pkg::ctl_type ctl_chain [0:fpc_pkg::PLANE_COUNT];
   logic [fpc_pkg::ROW_COUNT-1:0][VALUE_WIDTH-1:0]  rows_chain  [0:fpc_pkg::PLANE_COUNT];
   logic [fpc_pkg::AXIS_COUNT-1:0][VALUE_WIDTH-1:0] point_chain [0:fpc_pkg::PLANE_COUNT];

   // Admission: count test words not yet delivered so the queue never overflows
   assign req_stall  = pending_ff == fpc_pkg::CNT_W'(fpc_pkg::FIFO_DEPTH);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (req_accept && req_kind == fpc_pkg::KIND_TEST && !rsp_accept) begin
         pending_in = pending_ff + 1'b1;
      end else if (!(req_accept && req_kind == fpc_pkg::KIND_TEST) && rsp_accept) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // Head of the chain: a test word starts out in view
   always_comb begin
      ctl_chain[0].valid   = req_accept;
      ctl_chain[0].kind    = req_kind;
      ctl_chain[0].column  = req_column;
      ctl_chain[0].in_view = 1'b1;
   end

   assign rows_chain[0]  = {req_row3_value, req_row2_value, req_row1_value, req_row0_value};
   assign point_chain[0] = {req_point_z, req_point_y, req_point_x};

   // Plane cells: left, right, bottom, top, near, far
   for (genvar p = 0; p < fpc_pkg::PLANE_COUNT; p++) begin : g_cell
      fpc_cell #(
         .VALUE_WIDTH   (VALUE_WIDTH),
         .FRACTION_BITS (FRACTION_BITS),
         .PLANE_INDEX   (p)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (ctl_chain[p]),
         .in_rows   (rows_chain[p]),
         .in_point  (point_chain[p]),
         .out_ctl   (ctl_chain[p+1]),
         .out_rows  (rows_chain[p+1]),
         .out_point (point_chain[p+1])
      );
   end

   // Tail: test words leave their verdict in the queue
   assign result_push = ctl_chain[fpc_pkg::PLANE_COUNT].valid
                     && ctl_chain[fpc_pkg::PLANE_COUNT].kind == fpc_pkg::KIND_TEST;

   fpc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (ctl_chain[fpc_pkg::PLANE_COUNT].in_view),
      .pop       (rsp_accept),
      .out_valid (rsp_valid),
      .out_data  (rsp_inside_res)
   );

   // Checks
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= fpc_pkg::CNT_W'(fpc_pkg::FIFO_DEPTH))
      else $error("pending count above queue depth");

   a_push_counted: assert property (@(posedge clock) disable iff (reset)
      result_push |-> pending_ff != '0)
      else $error("result pushed with no test word pending");

   a_rsp_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("response word shown with no test word pending");

endmodule

// ===== tb/sv/frustum_cull_checker.sv =====
// Checker for the frustum point cull block: tracks plane state, predicts and compares results.
module frustum_cull_checker #(
   parameter int VALUE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_kind,
   input  logic [fpc_pkg::COLUMN_W-1:0]  req_column,
   input  logic signed [VALUE_WIDTH-1:0] req_row0_value,
   input  logic signed [VALUE_WIDTH-1:0] req_row1_value,
   input  logic signed [VALUE_WIDTH-1:0] req_row2_value,
   input  logic signed [VALUE_WIDTH-1:0] req_row3_value,
   input  logic signed [VALUE_WIDTH-1:0] req_point_x,
   input  logic signed [VALUE_WIDTH-1:0] req_point_y,
   input  logic signed [VALUE_WIDTH-1:0] req_point_z,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_inside_res,
   output int                            mismatches,
   output int                            pending
);

   // Plane coefficients, one bit wider than a matrix entry; index 3 is the w term
   logic signed [VALUE_WIDTH:0] plane_coef [fpc_pkg::PLANE_COUNT][fpc_pkg::ROW_COUNT];
   logic signed [VALUE_WIDTH:0] w_ext;
   logic signed [VALUE_WIDTH:0] axis_ext;

   // Inside flags of accepted test words, oldest first
   logic expected_inside [$];
   logic oldest_inside;

   // Exact signed distance of the point to each plane; inside when none is negative
   function automatic logic point_inside(input logic signed [VALUE_WIDTH-1:0] x,
                                         input logic signed [VALUE_WIDTH-1:0] y,
                                         input logic signed [VALUE_WIDTH-1:0] z);
      logic signed [127:0] sx;
      logic signed [127:0] sy;
      logic signed [127:0] sz;
      logic signed [127:0] ca;
      logic signed [127:0] cb;
      logic signed [127:0] cc;
      logic signed [127:0] cw;
      logic signed [127:0] distance;
      logic                all_clear;
      sx = 128'(x);
      sy = 128'(y);
      sz = 128'(z);
      all_clear = 1'b1;
      for (int p = 0; p < fpc_pkg::PLANE_COUNT; p++) begin
         ca = 128'(plane_coef[p][0]);
         cb = 128'(plane_coef[p][1]);
         cc = 128'(plane_coef[p][2]);
         cw = 128'(plane_coef[p][3]);
         // w is brought to the product scale before the sum
         distance = ca * sx + cb * sy + cc * sz + (cw <<< FRACTION_BITS);
         if (distance < 0) all_clear = 1'b0;
      end
      return all_clear;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] cull check: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < fpc_pkg::PLANE_COUNT; p++)
            for (int c = 0; c < fpc_pkg::ROW_COUNT; c++)
               plane_coef[p][c] = '0;
         expected_inside.delete();
         mismatches = 0;
      end else begin
         // Result side first, so a word accepted this edge is never matched early
         if (rsp_valid && !rsp_stall) begin
            if (expected_inside.size() == 0) begin
               report_mismatch("result word with no test word outstanding");
            end else begin
               oldest_inside = expected_inside.pop_front();
               if (rsp_inside_res !== oldest_inside)
                  report_mismatch($sformatf("inside_res got %0b, expected %0b",
                                            rsp_inside_res, oldest_inside));
            end
         end
         // Request side: a load rewrites one column of all six planes
         if (req_valid && !req_stall) begin
            if (req_kind == fpc_pkg::KIND_LOAD) begin
               w_ext = (VALUE_WIDTH+1)'(req_row3_value);
               for (int k = 0; k < fpc_pkg::AXIS_COUNT; k++) begin
                  case (k)
                     0: begin
                        axis_ext = (VALUE_WIDTH+1)'(req_row0_value);
                     end
                     1: begin
                        axis_ext = (VALUE_WIDTH+1)'(req_row1_value);
                     end
                     default: begin
                        axis_ext = (VALUE_WIDTH+1)'(req_row2_value);
                     end
                  endcase
                  plane_coef[2*k][req_column]   = w_ext + axis_ext;
                  plane_coef[2*k+1][req_column] = w_ext - axis_ext;
               end
            end else begin
               expected_inside.push_back(point_inside(req_point_x, req_point_y, req_point_z));
            end
         end
      end
      pending = expected_inside.size();
   end

endmodule

// ===== tb/sv/tb_frustum_point_cull.sv =====
// Testbench top for the frustum point cull block: stimulus, response stalls and verdict.
module tb_frustum_point_cull;

   localparam int VALUE_WIDTH   = 32;
   localparam int FRACTION_BITS = 16;
   localparam int ONE           = 1 << FRACTION_BITS;
   localparam int RANDOM_WORDS  = 1800;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_CYCLES  = 40;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   localparam value_type MAXV = 32'sh7fff_ffff;
   localparam value_type MINV = 32'sh8000_0000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_kind;
   logic [fpc_pkg::COLUMN_W-1:0] req_column;
   value_type                    req_row0_value;
   value_type                    req_row1_value;
   value_type                    req_row2_value;
   value_type                    req_row3_value;
   value_type                    req_point_x;
   value_type                    req_point_y;
   value_type                    req_point_z;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_inside_res;

   int mismatches;
   int pending;
   int cycle_count = 0;
   int words_sent  = 0;
   int stall_left  = 0;
   logic calm = 1'b0;

   int batch_mode;
   int batch_tests;
   int col_order [4];
   int swap_idx;
   int swap_tmp;

   always #1 clock = ~clock;

   frustum_point_cull #(
      .VALUE_WIDTH  (VALUE_WIDTH),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_column    (req_column),
      .req_row0_value(req_row0_value),
      .req_row1_value(req_row1_value),
      .req_row2_value(req_row2_value),
      .req_row3_value(req_row3_value),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_point_z   (req_point_z),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_inside_res(rsp_inside_res)
   );

   frustum_cull_checker #(
      .VALUE_WIDTH  (VALUE_WIDTH),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_column    (req_column),
      .req_row0_value(req_row0_value),
      .req_row1_value(req_row1_value),
      .req_row2_value(req_row2_value),
      .req_row3_value(req_row3_value),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_point_z   (req_point_z),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_inside_res(rsp_inside_res),
      .mismatches    (mismatches),
      .pending       (pending)
   );

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 82) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Signed value spread evenly over -span..span
   function automatic value_type near(input int span);
      int v;
      v = int'($urandom_range(0, 2 * span)) - span;
      return value_type'(v);
   endfunction

   // Matrix entry of a well-formed view box: positive diagonal, small elsewhere
   function automatic value_type box_entry(input int col, input int row);
      if (col == row) return value_type'($urandom_range(ONE / 4, 4 * ONE));
      return near(ONE / 16);
   endfunction

   // Result side holds stall for random stretches, dropped entirely while calm
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_left = pick_gap();
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // One request word: optional idle, then hold it until accepted
   task automatic send_word(input logic kind, input logic [fpc_pkg::COLUMN_W-1:0] col,
                            input value_type r0, input value_type r1, input value_type r2,
                            input value_type r3, input value_type x, input value_type y,
                            input value_type z);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      = 1'b1;
      req_kind       = kind;
      req_column     = col;
      req_row0_value = r0;
      req_row1_value = r1;
      req_row2_value = r2;
      req_row3_value = r3;
      req_point_x    = x;
      req_point_y    = y;
      req_point_z    = z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // Load word; the point fields carry noise
   task automatic load_column(input int col, input value_type r0, input value_type r1,
                              input value_type r2, input value_type r3);
      send_word(fpc_pkg::KIND_LOAD, fpc_pkg::COLUMN_W'(col), r0, r1, r2, r3,
                $urandom(), $urandom(), $urandom());
   endtask

   task automatic load_box_column(input int col);
      load_column(col, box_entry(col, 0), box_entry(col, 1), box_entry(col, 2),
                  box_entry(col, 3));
   endtask

   // Test word; the load fields carry noise
   task automatic test_point(input value_type x, input value_type y, input value_type z);
      send_word(fpc_pkg::KIND_TEST, fpc_pkg::COLUMN_W'($urandom()), $urandom(), $urandom(),
                $urandom(), $urandom(), x, y, z);
   endtask

   initial begin
      req_valid      = 1'b0;
      req_kind       = fpc_pkg::KIND_LOAD;
      req_column     = '0;
      req_row0_value = '0;
      req_row1_value = '0;
      req_row2_value = '0;
      req_row3_value = '0;
      req_point_x    = '0;
      req_point_y    = '0;
      req_point_z    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Planes all zero after reset: any point is inside
      test_point(MAXV, MINV, '0);
      test_point(MINV, MAXV, MAXV);

      // Identity matrix: unit box around the origin
      load_column(0, ONE, 0, 0, 0);
      load_column(1, 0, ONE, 0, 0);
      load_column(2, 0, 0, ONE, 0);
      load_column(3, 0, 0, 0, ONE);
      test_point('0, '0, '0);
      test_point(-ONE, '0, '0);         // on the left plane, distance zero
      test_point(-ONE - 1, '0, '0);     // one step beyond it
      test_point(ONE, ONE, ONE);
      test_point('0, '0, ONE + 1);
      test_point(MAXV, '0, '0);

      // Only w reloaded: the other columns keep their values
      load_column(3, 0, 0, 0, 2 * ONE);
      test_point(-ONE - 1, '0, '0);

      // w of zero: planes through the origin
      load_column(3, 0, 0, 0, 0);
      test_point('0, '0, '0);
      test_point(1, '0, '0);

      // Full-scale entries and points
      load_column(0, MINV, MAXV, MINV, MAXV);
      load_column(1, MAXV, MINV, MAXV, MINV);
      load_column(2, MAXV, MAXV, MINV, MINV);
      load_column(3, MINV, MINV, MINV, MINV);
      test_point(MAXV, MAXV, MAXV);
      test_point(MINV, MINV, MINV);
      test_point(MINV, MAXV, '0);

      // Random batches, mostly a well-formed matrix followed by point tests
      while (words_sent < RANDOM_WORDS + 25) begin
         calm       = ($urandom_range(0, 5) == 0);
         batch_mode = $urandom_range(0, 9);
         if (batch_mode <= 5) begin
            for (int i = 0; i < 4; i++) col_order[i] = i;
            for (int i = 3; i > 0; i--) begin
               swap_idx            = $urandom_range(0, i);
               swap_tmp            = col_order[i];
               col_order[i]        = col_order[swap_idx];
               col_order[swap_idx] = swap_tmp;
            end
            for (int i = 0; i < 4; i++) load_box_column(col_order[i]);
         end else if (batch_mode <= 7) begin
            // partial reload, some columns keep their old values
            repeat ($urandom_range(1, 2)) begin
               if ($urandom_range(0, 1) == 0)
                  load_box_column($urandom_range(0, 3));
               else
                  load_column($urandom_range(0, 3), $urandom(), $urandom(), $urandom(),
                              $urandom());
            end
         end else if (batch_mode == 8) begin
            for (int i = 0; i < 4; i++)
               load_column(i, $urandom(), $urandom(), $urandom(), $urandom());
         end
         batch_tests = $urandom_range(1, 30);
         for (int i = 0; i < batch_tests; i++) begin
            if ($urandom_range(0, 19) == 0) begin
               load_box_column($urandom_range(0, 3));
            end else if (batch_mode == 8 || $urandom_range(0, 9) == 0) begin
               test_point($urandom(), $urandom(), $urandom());
            end else begin
               test_point(near(3 * ONE), near(3 * ONE), near(3 * ONE));
            end
         end
      end
      calm = 1'b0;
      @(negedge clock);
      req_valid = 1'b0;

      // Drain outstanding results, then let the pipeline settle
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
src/fpc_pkg.sv
src/fpc_cell.sv
src/fpc_fifo.sv
src/frustum_point_cull.sv
tb/sv/frustum_cull_checker.sv
tb/sv/tb_frustum_point_cull.sv
